// ===== sv/ntcp_pkg.sv =====
package ntcp_pkg;

  localparam int unsigned STEPS_PER_SEMITONE_DEF = 8;
  localparam int unsigned ADJUST_BIT_DEF         = 12;

  // command and table select codes
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic SEL_FM      = 1'b0;
  localparam logic SEL_DIVIDER = 1'b1;

  // chip codes, anything above the last acts as the 10-bit psg
  localparam logic [2:0] CHIP_FM9   = 3'd0;
  localparam logic [2:0] CHIP_FM10  = 3'd1;
  localparam logic [2:0] CHIP_PSG12 = 3'd2;
  localparam logic [2:0] CHIP_WAVE  = 3'd3;
  localparam logic [2:0] CHIP_PSG10 = 3'd4;

  localparam logic [11:0] FNUM_MASK   = 12'hFFF;
  localparam logic [12:0] PSG12_LIMIT = 13'd4095;
  localparam logic [12:0] WAVE_LIMIT  = 13'd4096;
  localparam logic [12:0] PSG10_LIMIT = 13'd1023;
  localparam logic [12:0] FNUM_MAX    = 13'd1024;

  // table position width, enough for the deepest table (768 words)
  localparam int unsigned IDX_W = 10;

  // octave after folding, clamped where the result no longer changes
  localparam int unsigned OCT_W   = 7;
  localparam int          OCT_MIN = -2;
  localparam int          OCT_MAX = 40;

  localparam int unsigned MIDQ_DEPTH = 8;
  localparam int unsigned OUTQ_DEPTH = 4;

  typedef struct packed {
    logic               command;
    logic               table_select;
    logic [6:0]         table_index;
    logic [15:0]        table_word;
    logic [2:0]         chip;
    logic [7:0]         note;
    logic signed [15:0] bend;
  } in_item_t;

  typedef struct packed {
    logic [12:0] pitch_value;
    logic [2:0]  octave_block;
    logic        out_of_range;
  } out_item_t;

  // classified transaction between front and back
  typedef struct packed {
    logic                    is_write;
    logic                    wr_en;
    logic                    sel;
    logic [IDX_W-1:0]        index;
    logic [15:0]             word;
    logic [2:0]              chip;
    logic signed [OCT_W-1:0] octave;
  } mid_item_t;

endpackage

// ===== sv/ntcp_ram.sv =====
module ntcp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ntcp_fifo.sv =====
module ntcp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign count_o = count_q;

endmodule

// ===== sv/ntcp_front.sv =====
module ntcp_front #(
  parameter int unsigned STEPS_PER_SEMITONE = ntcp_pkg::STEPS_PER_SEMITONE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ntcp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  output ntcp_pkg::mid_item_t out_item_o,
  output logic [2:0]          busy_count_o
);

  localparam int unsigned DEPTH   = 12 * STEPS_PER_SEMITONE;
  // bias that makes the bent index non-negative, a whole number of octaves
  localparam int unsigned WRAPS   = (32768 + DEPTH - 1) / DEPTH;
  localparam int unsigned OFFSET  = WRAPS * DEPTH;
  localparam int unsigned U_MAX   = 11 * STEPS_PER_SEMITONE + 32767 + OFFSET;
  localparam int unsigned UW      = $clog2(U_MAX + 1);
  localparam int unsigned RECIP   = (1 << UW) / DEPTH;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PW      = UW + RECIP_W;
  localparam int unsigned QW      = $clog2(U_MAX / DEPTH + 2);
  localparam int unsigned RW      = $clog2(2 * DEPTH);
  localparam int unsigned OW      = QW + 2;
  localparam int unsigned OCT_W   = ntcp_pkg::OCT_W;
  localparam int unsigned IDX_W   = ntcp_pkg::IDX_W;

  typedef struct packed {
    logic        is_write;
    logic        wr_en;
    logic        sel;
    logic [6:0]  index;
    logic [15:0] word;
    logic [2:0]  chip;
  } carry_t;

  logic [4:0] valid_q;
  carry_t     c_q [4];
  carry_t     c_d;

  logic [4:0]         oct1_q, oct2_q, oct3_q, oct4_q;
  logic [7:0]         note1_q;
  logic signed [15:0] bend1_q;
  logic [UW-1:0]      u2_q, u3_q, u2_d;
  logic [PW-1:0]      prod3_q, prod3_d;
  logic [QW-1:0]      q4_q, q4_d;
  logic [RW-1:0]      r4_q, r4_d;

  logic [15:0] n171;
  logic [7:0]  rem2;
  logic [15:0] bend_bias;
  logic [UW-1:0] r0;

  logic [RW-1:0]          rc;
  logic [QW-1:0]          qc;
  logic signed [OW-1:0]   oct_sum;
  logic signed [OCT_W-1:0] oct_clamped;
  ntcp_pkg::mid_item_t    out_d;

  always_comb begin
    c_d.is_write = (in_item_i.command == ntcp_pkg::CMD_WRITE);
    c_d.wr_en    = (32'(in_item_i.table_index) < DEPTH);
    c_d.sel      = in_item_i.table_select;
    c_d.index    = in_item_i.table_index;
    c_d.word     = in_item_i.table_word;
    c_d.chip     = in_item_i.chip;
    // note / 12 by reciprocal, exact over the 8-bit note range
    n171 = 16'(in_item_i.note) * 16'd171;
  end

  always_comb begin
    rem2      = note1_q - {oct1_q, 3'b000} - {1'b0, oct1_q, 2'b00};
    bend_bias = {~bend1_q[15], bend1_q[14:0]};
    u2_d      = UW'(32'(rem2[3:0]) * STEPS_PER_SEMITONE) + UW'(bend_bias)
              + UW'(OFFSET - 32768);
  end

  assign prod3_d = PW'(u2_q) * PW'(RECIP);

  always_comb begin
    // estimate is exact or one short
    q4_d = QW'(prod3_q >> UW);
    r0   = u3_q - UW'(32'(q4_d) * DEPTH);
    r4_d = RW'(r0);
  end

  always_comb begin
    if (32'(r4_q) >= DEPTH) begin
      rc = r4_q - RW'(DEPTH);
      qc = q4_q + 1'b1;
    end else begin
      rc = r4_q;
      qc = q4_q;
    end
    oct_sum = $signed(OW'(oct4_q)) + $signed(OW'(qc)) - $signed(OW'(WRAPS));
    if (oct_sum < OW'(ntcp_pkg::OCT_MIN)) begin
      oct_clamped = OCT_W'(ntcp_pkg::OCT_MIN);
    end else if (oct_sum > OW'(ntcp_pkg::OCT_MAX)) begin
      oct_clamped = OCT_W'(ntcp_pkg::OCT_MAX);
    end else begin
      oct_clamped = OCT_W'(oct_sum);
    end
    out_d.is_write = c_q[3].is_write;
    out_d.wr_en    = c_q[3].wr_en;
    out_d.sel      = c_q[3].sel;
    out_d.index    = c_q[3].is_write ? IDX_W'(c_q[3].index) : IDX_W'(rc);
    out_d.word     = c_q[3].word;
    out_d.chip     = c_q[3].chip;
    out_d.octave   = oct_clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c_q[0]  <= c_d;
    c_q[1]  <= c_q[0];
    c_q[2]  <= c_q[1];
    c_q[3]  <= c_q[2];
    oct1_q  <= n171[15:11];
    note1_q <= in_item_i.note;
    bend1_q <= in_item_i.bend;
    oct2_q  <= oct1_q;
    u2_q    <= u2_d;
    oct3_q  <= oct2_q;
    u3_q    <= u2_q;
    prod3_q <= prod3_d;
    oct4_q  <= oct3_q;
    q4_q    <= q4_d;
    r4_q    <= r4_d;
    out_item_o <= out_d;
  end

  assign out_valid_o  = valid_q[4];
  assign busy_count_o = 3'($countones(valid_q));

endmodule

// ===== sv/ntcp_back.sv =====
module ntcp_back #(
  parameter int unsigned STEPS_PER_SEMITONE = ntcp_pkg::STEPS_PER_SEMITONE_DEF,
  parameter int unsigned ADJUST_BIT         = ntcp_pkg::ADJUST_BIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  ntcp_pkg::mid_item_t item_i,
  output logic                res_valid_o,
  output ntcp_pkg::out_item_t res_o,
  output logic                busy_o
);

  localparam int unsigned DEPTH = 12 * STEPS_PER_SEMITONE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OCT_W = ntcp_pkg::OCT_W;

  logic [AW-1:0] addr;
  logic          fm_we, div_we, rd_en;
  logic [15:0]   fm_rdata, div_rdata;

  logic                    conv_valid_q;
  logic [2:0]              chip_q;
  logic signed [OCT_W-1:0] oct_q;

  logic signed [OCT_W-1:0] blk;
  logic [1:0]              fm_sh;
  logic [12:0]             fm_t;
  logic [5:0]              div_sh;
  logic [16:0]             div_t;
  logic [15:0]             div_v;
  logic [12:0]             limit;

  assign addr   = item_i.index[AW-1:0];
  assign fm_we  = item_valid_i && item_i.is_write && item_i.wr_en
                  && (item_i.sel == ntcp_pkg::SEL_FM);
  assign div_we = item_valid_i && item_i.is_write && item_i.wr_en
                  && (item_i.sel == ntcp_pkg::SEL_DIVIDER);
  assign rd_en  = item_valid_i && !item_i.is_write;

  ntcp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_fm_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (addr),
    .wdata_i (item_i.word),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (fm_rdata)
  );

  ntcp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_div_ram (
    .clk_i   (clk_i),
    .we_i    (div_we),
    .waddr_i (addr),
    .wdata_i (item_i.word),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (div_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_valid_q <= 1'b0;
    end else begin
      conv_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      chip_q <= item_i.chip;
      oct_q  <= item_i.octave;
    end
  end

  always_comb begin
    case (chip_q)
      ntcp_pkg::CHIP_PSG12: limit = ntcp_pkg::PSG12_LIMIT;
      ntcp_pkg::CHIP_WAVE:  limit = ntcp_pkg::WAVE_LIMIT;
      ntcp_pkg::CHIP_PSG10: limit = ntcp_pkg::PSG10_LIMIT;
      default:              limit = ntcp_pkg::PSG10_LIMIT;
    endcase

    // fm: adjusted block and rounded f-number
    blk   = oct_q - OCT_W'(fm_rdata[ADJUST_BIT]);
    fm_sh = (chip_q == ntcp_pkg::CHIP_FM10) ? 2'd2 : 2'd3;
    fm_t  = {1'b0, fm_rdata[11:0] & ntcp_pkg::FNUM_MASK} >> (fm_sh - 2'd1);

    // divider: round-shift by octave+3, zero once past the word
    div_sh = 6'(oct_q + OCT_W'(2));
    div_t  = {1'b0, div_rdata} >> div_sh;
    div_v  = 16'((div_t + 17'd1) >> 1);

    res_o = '0;
    if (chip_q == ntcp_pkg::CHIP_FM9 || chip_q == ntcp_pkg::CHIP_FM10) begin
      if (blk >= 8) begin
        res_o.pitch_value  = {1'b0, ntcp_pkg::FNUM_MASK} >> fm_sh;
        res_o.octave_block = 3'd7;
        res_o.out_of_range = 1'b1;
      end else if (blk < 0) begin
        res_o.out_of_range = 1'b1;
      end else begin
        res_o.pitch_value  = (fm_t + 13'd1) >> 1;
        res_o.octave_block = blk[2:0];
      end
    end else begin
      if (oct_q < -1) begin
        res_o.pitch_value  = limit;
        res_o.out_of_range = 1'b1;
      end else if (div_v > {3'b000, limit}) begin
        res_o.pitch_value  = limit;
        res_o.out_of_range = 1'b1;
      end else if (div_v == '0) begin
        res_o.pitch_value  = 13'd1;
        res_o.out_of_range = 1'b1;
      end else begin
        res_o.pitch_value  = div_v[12:0];
      end
    end
  end

  assign res_valid_o = conv_valid_q;
  assign busy_o      = conv_valid_q;

endmodule

// ===== sv/note_to_chip_pitch_registers.sv =====
// note to chip pitch converter
//
// input queue side: push / full, one transaction per cycle while full is low.
// a write transaction stores table_word at an in-range table_index of the fm
// or divider table and gives no result. a convert transaction gives one
// result: an f-number and block for fm chips, or a tone divider for others.
// result queue side: empty / pop; the oldest result sits on result_o while
// empty is low and leaves on a cycle with pop high.
//
// a convert transaction passes the front pipeline, the mid queue, the back
// part's table read and the result queue. throughput while full is low: one
// transaction per cycle, set by the five-stage front pipeline (octave split,
// bend, reciprocal multiply, remainder, wrap fix) and a registered table read.
// a stalled result side fills the result queue, then the mid queue; full
// rises once the mid queue plus the front pipeline hold 8 transactions.
// reset empties both queues and the pipelines; table contents are undefined
// until written, with no clearing pass.
module note_to_chip_pitch_registers #(
  parameter int unsigned STEPS_PER_SEMITONE = ntcp_pkg::STEPS_PER_SEMITONE_DEF,
  parameter int unsigned ADJUST_BIT         = ntcp_pkg::ADJUST_BIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ntcp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ntcp_pkg::out_item_t result_o
);

  localparam int unsigned MIDQ_DEPTH = ntcp_pkg::MIDQ_DEPTH;
  localparam int unsigned OUTQ_DEPTH = ntcp_pkg::OUTQ_DEPTH;
  localparam int unsigned MIDQ_CW    = $clog2(MIDQ_DEPTH + 1);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned SUM_W      = MIDQ_CW + 2;

  logic                in_take;
  logic                front_valid;
  ntcp_pkg::mid_item_t front_item;
  logic [2:0]          front_busy;

  logic                midq_pop, midq_empty, midq_full;
  logic [MIDQ_CW-1:0]  midq_count;
  ntcp_pkg::mid_item_t midq_head;

  logic                back_valid, back_busy;
  ntcp_pkg::out_item_t back_res;

  logic                outq_pop, outq_full;
  logic [OUTQ_CW-1:0]  outq_count;

  // credit check: room in the mid queue for everything still in the front
  assign full    = (SUM_W'(midq_count) + SUM_W'(front_busy)) >= SUM_W'(MIDQ_DEPTH);
  assign in_take = push && !full;

  ntcp_front #(.STEPS_PER_SEMITONE(STEPS_PER_SEMITONE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_take),
    .in_item_i    (in_item_i),
    .out_valid_o  (front_valid),
    .out_item_o   (front_item),
    .busy_count_o (front_busy)
  );

  ntcp_fifo #(.WIDTH($bits(ntcp_pkg::mid_item_t)), .DEPTH(MIDQ_DEPTH)) u_midq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .pop_i   (midq_pop),
    .data_o  (midq_head),
    .empty_o (midq_empty),
    .full_o  (midq_full),
    .count_o (midq_count)
  );

  // same credit scheme towards the result queue
  assign midq_pop = !midq_empty
                    && ((OUTQ_CW'(outq_count) + OUTQ_CW'(back_busy)) < OUTQ_CW'(OUTQ_DEPTH));

  ntcp_back #(
    .STEPS_PER_SEMITONE (STEPS_PER_SEMITONE),
    .ADJUST_BIT         (ADJUST_BIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (midq_pop),
    .item_i       (midq_head),
    .res_valid_o  (back_valid),
    .res_o        (back_res),
    .busy_o       (back_busy)
  );

  assign outq_pop = pop && !empty;

  ntcp_fifo #(.WIDTH($bits(ntcp_pkg::out_item_t)), .DEPTH(OUTQ_DEPTH)) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_res),
    .pop_i   (outq_pop),
    .data_o  (result_o),
    .empty_o (empty),
    .full_o  (outq_full),
    .count_o (outq_count)
  );

  a_midq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_valid && midq_full))
    else $error("mid queue pushed while full");

  a_outq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(back_valid && outq_full))
    else $error("result queue pushed while full");

  a_pitch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.pitch_value <= ntcp_pkg::WAVE_LIMIT))
    else $error("pitch value above the widest limit");

  a_fm_fnum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.out_of_range && result_o.octave_block != 3'd0)
      |-> (result_o.pitch_value <= ntcp_pkg::FNUM_MAX))
    else $error("f-number too wide for a non-zero block");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_WORDS = 12 * ntcp_pkg::STEPS_PER_SEMITONE_DEF;
  localparam int unsigned ADJUST      = ntcp_pkg::ADJUST_BIT_DEF;
  localparam logic        CMD_CONVERT = 1'b1;
  // spare chip codes, all behave as the 10-bit psg
  localparam logic [2:0]  CHIP_SPARE5 = 3'd5;
  localparam logic [2:0]  CHIP_SPARE6 = 3'd6;
  localparam logic [2:0]  CHIP_SPARE7 = 3'd7;

  typedef struct {
    ntcp_pkg::in_item_t  item;
    bit                  known;
    ntcp_pkg::out_item_t want;
  } dir_row_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                push      = 1'b0;
  logic                pop       = 1'b0;
  ntcp_pkg::in_item_t  in_item_i = '0;
  logic                full;
  logic                empty;
  ntcp_pkg::out_item_t result_o;

  logic [15:0]         fm_words  [TABLE_WORDS];
  logic [15:0]         div_words [TABLE_WORDS];
  ntcp_pkg::out_item_t pitch_expected [$];
  dir_row_t            directed_rows [$];

  int mismatches     = 0;
  int writes_sent    = 0;
  int ignored_writes = 0;
  int converts_sent  = 0;
  int results_seen   = 0;
  int flagged_seen   = 0;
  int full_stalls    = 0;
  bit hold_request   = 1'b0;

  note_to_chip_pitch_registers dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("timed out with %0d results outstanding", pitch_expected.size());
    $display("FAIL note_to_chip_pitch_registers");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 20) begin
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic int unsigned round_down_shift(input int unsigned v, input int sh);
    if (sh < 1) begin
      return v;
    end
    if (sh - 1 >= 32) begin
      return 0;
    end
    v = v >> (sh - 1);
    return ((v + 1) >> 1) & 32'hFFFF;
  endfunction

  // updates the table copies on a write, returns 1 with the pitch on a convert
  function automatic bit predict_pitch(input ntcp_pkg::in_item_t it,
                                       output ntcp_pkg::out_item_t res);
    int          oct, semis, raw, q, r, blk, sh;
    int unsigned v, lim;
    logic [15:0] entry;
    res = '0;
    if (it.command == ntcp_pkg::CMD_WRITE) begin
      if (it.table_index < TABLE_WORDS) begin
        if (it.table_select == ntcp_pkg::SEL_FM) begin
          fm_words[it.table_index] = it.table_word;
        end else begin
          div_words[it.table_index] = it.table_word;
        end
      end
      return 1'b0;
    end
    oct   = it.note / 12;
    semis = it.note % 12;
    raw   = semis * ntcp_pkg::STEPS_PER_SEMITONE_DEF + int'($signed(it.bend));
    q     = raw / int'(TABLE_WORDS);
    r     = raw % int'(TABLE_WORDS);
    if (r < 0) begin
      r += TABLE_WORDS;
      q -= 1;
    end
    oct += q;
    if (it.chip <= ntcp_pkg::CHIP_FM10) begin
      sh    = (it.chip == ntcp_pkg::CHIP_FM10) ? 2 : 3;
      entry = fm_words[r];
      blk   = entry[ADJUST] ? oct - 1 : oct;
      if (blk >= 8) begin
        res.pitch_value  = 13'(ntcp_pkg::FNUM_MASK >> sh);
        res.octave_block = 3'd7;
        res.out_of_range = 1'b1;
      end else if (blk < 0) begin
        res.out_of_range = 1'b1;
      end else begin
        res.pitch_value  = 13'(round_down_shift(int'(entry[11:0]), sh));
        res.octave_block = 3'(blk);
      end
    end else begin
      lim = (it.chip == ntcp_pkg::CHIP_PSG12) ? ntcp_pkg::PSG12_LIMIT :
            (it.chip == ntcp_pkg::CHIP_WAVE)  ? ntcp_pkg::WAVE_LIMIT  :
                                                ntcp_pkg::PSG10_LIMIT;
      if (oct < -1) begin
        res.pitch_value  = 13'(lim);
        res.out_of_range = 1'b1;
      end else begin
        v = round_down_shift(int'(div_words[r]), oct + 3);
        if (v > lim) begin
          res.pitch_value  = 13'(lim);
          res.out_of_range = 1'b1;
        end else if (v == 0) begin
          res.pitch_value  = 13'd1;
          res.out_of_range = 1'b1;
        end else begin
          res.pitch_value = 13'(v);
        end
      end
    end
    return 1'b1;
  endfunction

  // every field random, callers then set the ones that matter
  function automatic ntcp_pkg::in_item_t noisy_item();
    ntcp_pkg::in_item_t it;
    it.command      = 1'($urandom);
    it.table_select = 1'($urandom);
    it.table_index  = 7'($urandom);
    it.table_word   = 16'($urandom);
    it.chip         = 3'($urandom);
    it.note         = 8'($urandom);
    it.bend         = 16'($urandom);
    return it;
  endfunction

  function automatic dir_row_t load_row(input logic sel, input logic [6:0] idx,
                                        input logic [15:0] word);
    dir_row_t row;
    row.item              = noisy_item();
    row.item.command      = ntcp_pkg::CMD_WRITE;
    row.item.table_select = sel;
    row.item.table_index  = idx;
    row.item.table_word   = word;
    row.known             = 1'b0;
    row.want              = '0;
    return row;
  endfunction

  function automatic dir_row_t conv_row(input logic [2:0] chip, input logic [7:0] note,
                                        input int bend, input bit known = 1'b0,
                                        input int value = 0, input int blk = 0,
                                        input bit flag = 1'b0);
    dir_row_t row;
    row.item         = noisy_item();
    row.item.command = CMD_CONVERT;
    row.item.chip    = chip;
    row.item.note    = note;
    row.item.bend    = 16'(bend);
    row.known        = known;
    row.want         = '{13'(value), 3'(blk), flag};
    return row;
  endfunction

  task automatic offer_item(input ntcp_pkg::in_item_t it, input bit known,
                            input ntcp_pkg::out_item_t want);
    ntcp_pkg::out_item_t res;
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    if (predict_pitch(it, res)) begin
      pitch_expected.push_back(known ? want : res);
      converts_sent++;
    end else begin
      writes_sent++;
      if (it.table_index >= TABLE_WORDS) begin
        ignored_writes++;
      end
    end
  endtask

  task automatic rest(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // result side: checks each result and stalls on its own pattern
  initial begin : result_side
    ntcp_pkg::out_item_t want;
    int                  mode_left;
    int                  stall_mode;
    int                  hold_left;
    mode_left  = 0;
    stall_mode = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        results_seen++;
        if (pitch_expected.size() == 0) begin
          report_mismatch("result with nothing outstanding, pitch_value",
                          int'(result_o.pitch_value), -1);
        end else begin
          want = pitch_expected.pop_front();
          if (result_o.pitch_value !== want.pitch_value) begin
            report_mismatch("pitch_value", int'(result_o.pitch_value), int'(want.pitch_value));
          end
          if (result_o.octave_block !== want.octave_block) begin
            report_mismatch("octave_block", int'(result_o.octave_block),
                            int'(want.octave_block));
          end
          if (result_o.out_of_range !== want.out_of_range) begin
            report_mismatch("out_of_range", int'(result_o.out_of_range),
                            int'(want.out_of_range));
          end
          if (want.out_of_range) begin
            flagged_seen++;
          end
        end
      end
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (stall_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    ntcp_pkg::in_item_t  it;
    ntcp_pkg::out_item_t none;
    int                  burst_left;
    int                  pick;
    none = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fill both tables so no conversion ever reads an unwritten word
    for (int i = 0; i < TABLE_WORDS; i++) begin
      it = noisy_item();
      it.command      = ntcp_pkg::CMD_WRITE;
      it.table_select = ntcp_pkg::SEL_FM;
      it.table_index  = 7'(i);
      offer_item(it, 1'b0, none);
      it = noisy_item();
      it.command      = ntcp_pkg::CMD_WRITE;
      it.table_select = ntcp_pkg::SEL_DIVIDER;
      it.table_index  = 7'(i);
      offer_item(it, 1'b0, none);
    end

    directed_rows = '{
      load_row(ntcp_pkg::SEL_FM,      7'd0,  16'h1FFF),
      load_row(ntcp_pkg::SEL_DIVIDER, 7'd0,  16'hFFFF),
      load_row(ntcp_pkg::SEL_DIVIDER, 7'd95, 16'h0000),
      // writes past the table end must leave word 0 alone
      load_row(ntcp_pkg::SEL_FM,      7'd96, 16'h0000),
      load_row(ntcp_pkg::SEL_DIVIDER, 7'd96, 16'h0000),
      conv_row(ntcp_pkg::CHIP_FM9,    8'd0,   0,      1'b1, 0,    0, 1'b1),
      conv_row(ntcp_pkg::CHIP_FM10,   8'd255, 32767,  1'b1, 1023, 7, 1'b1),
      conv_row(ntcp_pkg::CHIP_FM9,    8'd255, -32768, 1'b1, 0,    0, 1'b1),
      // rounding carry out of the f-number
      conv_row(ntcp_pkg::CHIP_FM9,    8'd96,  0,      1'b1, 512,  7, 1'b0),
      conv_row(ntcp_pkg::CHIP_FM10,   8'd96,  0,      1'b1, 1024, 7, 1'b0),
      conv_row(ntcp_pkg::CHIP_FM9,    8'd108, 0,      1'b1, 511,  7, 1'b1),
      conv_row(ntcp_pkg::CHIP_PSG12,  8'd0,   -96,    1'b1, 4095, 0, 1'b1),
      conv_row(ntcp_pkg::CHIP_PSG12,  8'd0,   -97,    1'b1, 4095, 0, 1'b1),
      conv_row(ntcp_pkg::CHIP_WAVE,   8'd0,   0,      1'b1, 4096, 0, 1'b1),
      conv_row(ntcp_pkg::CHIP_PSG10,  8'd11,  7,      1'b1, 1,    0, 1'b1),
      conv_row(CHIP_SPARE7,           8'd0,   0,      1'b1, 1023, 0, 1'b1),
      conv_row(CHIP_SPARE5,           8'd255, 32767,  1'b1, 1,    0, 1'b1),
      conv_row(CHIP_SPARE6,           8'd0,   96,     1'b1, 1023, 0, 1'b1),
      load_row(ntcp_pkg::SEL_DIVIDER, 7'd0,  16'h0400),
      conv_row(ntcp_pkg::CHIP_PSG12,  8'd0,   0),
      load_row(ntcp_pkg::SEL_FM,      7'd95, 16'h0800),
      conv_row(ntcp_pkg::CHIP_FM10,   8'd11,  7),
      load_row(ntcp_pkg::SEL_FM,      7'd0,  16'hEFFF),
      conv_row(ntcp_pkg::CHIP_FM9,    8'd0,   0),
      conv_row(ntcp_pkg::CHIP_FM9,    8'd60,  -1)
    };
    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].item, directed_rows[k].known, directed_rows[k].want);
      if ($urandom_range(0, 3) == 0) begin
        rest($urandom_range(1, 3));
      end
    end

    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < 830; n++) begin
      if (n == 300) begin
        // result side holds off while transactions keep coming
        hold_request = 1'b1;
        burst_left   = 80;
      end
      if (n == 650) begin
        rest(1);
        while (pitch_expected.size() != 0) @(posedge clk_i);
      end
      it   = noisy_item();
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        it.command     = ntcp_pkg::CMD_WRITE;
        it.table_index = 7'($urandom_range(0, TABLE_WORDS - 1));
      end else if (pick < 18) begin
        it.command     = ntcp_pkg::CMD_WRITE;
        it.table_index = 7'($urandom_range(TABLE_WORDS, 127));
      end else begin
        it.command = CMD_CONVERT;
        it.chip    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
        it.note    = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 119));
        case ($urandom_range(0, 9))
          0, 1:    it.bend = 16'($urandom);
          2, 3, 4: it.bend = 16'(int'($urandom_range(0, 2000)) - 1000);
          default: it.bend = 16'(int'($urandom_range(0, 64)) - 32);
        endcase
      end
      offer_item(it, 1'b0, none);
      burst_left--;
      if (burst_left <= 0) begin
        rest($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 40);
      end
    end

    rest(1);
    while (pitch_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pitch_expected.size() != 0) begin
      report_mismatch("results never delivered", 0, pitch_expected.size());
    end
    $display("covered %0d table writes (%0d past the table end) and %0d conversions",
             writes_sent, ignored_writes, converts_sent);
    $display("checked %0d results, %0d of them clamped or silenced, input stalled %0d cycles",
             results_seen, flagged_seen, full_stalls);
    if (mismatches == 0) begin
      $display("PASS note_to_chip_pitch_registers");
    end else begin
      $display("FAIL note_to_chip_pitch_registers");
    end
    $finish;
  end

endmodule
